@@ design/bounded_stack_with_search_unit_macros.svh @@
// Assertion macros for the bounded stack with search unit.
// Included by the datapath, which checks its own logic; no dependencies.
`ifndef BOUNDED_STACK_WITH_SEARCH_UNIT_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bss: same-cycle property violated");

// Next-cycle implication, checked out of reset.
`define BSS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bss: next-cycle property violated");

`endif

@@ design/bss_pkg.sv @@
// Shared types, codes and sizes of the bounded stack with search unit.
// No dependencies; used by the controller, the datapath and the top level.
package bss_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // operation codes
    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_SEARCH  = 3'd2;
    localparam logic [2:0] OP_REPLACE = 3'd3;
    localparam logic [2:0] OP_DISPLAY = 3'd4;
    localparam logic [2:0] OP_SORT    = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // which result the datapath loads into the output register
    typedef enum logic [3:0] {
        RES_FULL,
        RES_EMPTY,
        RES_PUSH,
        RES_POP,
        RES_MATCH,
        RES_NOT_FOUND,
        RES_REPLACE,
        RES_DISPLAY,
        RES_SORT
    } res_kind_t;

    typedef struct packed {
        logic      load_req;
        logic      count_inc;
        logic      count_dec;
        logic      mem_we;
        logic      wr_top;
        logic      mem_re;
        logic      rd_top;
        logic      idx_clr;
        logic      idx_inc;
        logic      match_clr;
        logic      match_inc;
        logic      pend_clr;
        logic      pend_set;
        logic      best_clr;
        logic      best_upd;
        logic      prev_clr;
        logic      prev_take;
        logic      k_clr;
        logic      k_inc;
        logic      emit;
        res_kind_t kind;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic idx_last;
        logic k_last;
        logic hit;
        logic pend_valid;
        logic out_busy;
    } dp_stat_t;

    // mask a count or position to the 4-bit result fields
    function automatic logic [3:0] to_nib(input logic [CNT_W-1:0] v);
        logic [CNT_W+3:0] wide;
        wide = {4'b0000, v};
        return wide[3:0];
    endfunction

endpackage

@@ design/bss_ctrl.sv @@
// Sequencer of the bounded stack with search unit.
// Depends on bss_pkg; drives the datapath by dp_cmd_t and reads dp_stat_t.
module bss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2:0]        operation,
    output logic              in_stall,
    input  bss_pkg::dp_stat_t stat,
    output bss_pkg::dp_cmd_t  cmd
);
    import bss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ERR,
        S_PUSH_OUT,
        S_POP_OUT,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SEARCH_END,
        S_REPL_OUT,
        S_SORT_RD,
        S_SORT_EV,
        S_SORT_OUT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] op_reg;
    logic [2:0] op_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.kind   = RES_FULL;
        case (state_reg)
            S_IDLE:
            begin
                // drop unknown codes without leaving idle
                if (in_valid && (operation <= OP_SORT))
                begin
                    op_next      = operation;
                    cmd.load_req = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                if (op_reg == OP_PUSH)
                begin
                    if (stat.count_full)
                        state_next = S_ERR;
                    else
                    begin
                        cmd.mem_we    = 1'b1;
                        cmd.wr_top    = 1'b1;
                        cmd.count_inc = 1'b1;
                        state_next    = S_PUSH_OUT;
                    end
                end
                else if (stat.count_zero)
                    state_next = S_ERR;
                else if (op_reg == OP_POP)
                begin
                    cmd.mem_re    = 1'b1;
                    cmd.rd_top    = 1'b1;
                    cmd.count_dec = 1'b1;
                    state_next    = S_POP_OUT;
                end
                else if (op_reg == OP_SORT)
                begin
                    cmd.idx_clr  = 1'b1;
                    cmd.best_clr = 1'b1;
                    cmd.prev_clr = 1'b1;
                    cmd.k_clr    = 1'b1;
                    state_next   = S_SORT_RD;
                end
                else
                begin
                    cmd.idx_clr   = 1'b1;
                    cmd.match_clr = 1'b1;
                    cmd.pend_clr  = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_ERR:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = (op_reg == OP_PUSH) ? RES_FULL : RES_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_PUSH_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = RES_PUSH;
                    state_next = S_IDLE;
                end
            end
            S_POP_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = RES_POP;
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                cmd.mem_re = 1'b1;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                case (op_reg)
                    OP_SEARCH:
                    begin
                        // hold while a pending match cannot be flushed
                        if (!(stat.hit && stat.pend_valid && stat.out_busy))
                        begin
                            if (stat.hit)
                            begin
                                cmd.pend_set = 1'b1;
                                if (stat.pend_valid)
                                begin
                                    cmd.emit = 1'b1;
                                    cmd.kind = RES_MATCH;
                                    cmd.last = 1'b0;
                                end
                            end
                            if (stat.idx_last)
                                state_next = S_SEARCH_END;
                            else
                            begin
                                cmd.idx_inc = 1'b1;
                                state_next  = S_SCAN_RD;
                            end
                        end
                    end
                    OP_REPLACE:
                    begin
                        if (stat.hit)
                        begin
                            cmd.mem_we    = 1'b1;
                            cmd.match_inc = 1'b1;
                        end
                        if (stat.idx_last)
                            state_next = S_REPL_OUT;
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        if (!stat.out_busy)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = RES_DISPLAY;
                            if (stat.idx_last)
                                state_next = S_IDLE;
                            else
                            begin
                                cmd.idx_inc = 1'b1;
                                state_next  = S_SCAN_RD;
                            end
                        end
                    end
                endcase
            end
            S_SEARCH_END:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = stat.pend_valid ? RES_MATCH : RES_NOT_FOUND;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REPL_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = RES_REPLACE;
                    state_next = S_IDLE;
                end
            end
            S_SORT_RD:
            begin
                cmd.mem_re = 1'b1;
                state_next = S_SORT_EV;
            end
            S_SORT_EV:
            begin
                cmd.best_upd = 1'b1;
                if (stat.idx_last)
                    state_next = S_SORT_OUT;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SORT_RD;
                end
            end
            S_SORT_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = RES_SORT;
                    cmd.prev_take = 1'b1;
                    cmd.best_clr  = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    if (stat.k_last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_SORT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

@@ design/bss_datapath.sv @@
// Storage, scan counters, sort selection and output register of the stack unit.
// Depends on bss_pkg and the assertion macros header; driven by bss_ctrl.
`include "bounded_stack_with_search_unit_macros.svh"

module bss_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] value,
    input  logic signed [31:0] new_value,
    input  logic               out_stall,
    input  bss_pkg::dp_cmd_t   cmd,
    output bss_pkg::dp_stat_t  stat,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic signed [31:0] data,
    output logic [3:0]         position,
    output logic [3:0]         matches_res,
    output logic [3:0]         count,
    output logic               last
);
    import bss_pkg::*;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] nval_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [CNT_W-1:0]   match_reg;
    logic               pend_valid_reg;
    logic [CNT_W-1:0]   pend_pos_reg;
    logic               best_valid_reg;
    logic signed [31:0] best_val_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               prev_valid_reg;
    logic signed [31:0] prev_val_reg;
    logic [IDX_W-1:0]   prev_idx_reg;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] data_reg;
    logic [3:0]         position_reg;
    logic [3:0]         matches_reg;
    logic [3:0]         count_out_reg;
    logic               last_reg;

    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   idx_pos;
    logic [CNT_W-1:0]   k_pos;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic signed [31:0] wr_data;
    logic               above_prev;
    logic               below_best;

    logic [1:0]         res_status;
    logic signed [31:0] res_data;
    logic [CNT_W-1:0]   res_pos;
    logic [CNT_W-1:0]   res_match;
    logic               res_last;

    assign cnt_m1  = count_reg - CNT_W'(1);
    assign idx_pos = CNT_W'(idx_reg) + CNT_W'(1);
    assign k_pos   = CNT_W'(k_reg) + CNT_W'(1);

    assign wr_addr = cmd.wr_top ? count_reg[IDX_W-1:0] : idx_reg;
    assign wr_data = cmd.wr_top ? val_reg : nval_reg;
    assign rd_addr = cmd.rd_top ? cnt_m1[IDX_W-1:0] : idx_reg;

    assign stat.count_zero = (count_reg == {CNT_W{1'b0}});
    assign stat.count_full = (count_reg == CNT_W'(DEPTH));
    assign stat.idx_last   = (idx_pos == count_reg);
    assign stat.k_last     = (k_pos == count_reg);
    assign stat.hit        = (rdata_reg == val_reg);
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_busy   = out_valid_reg && out_stall;

    // next sorted element: smallest (value, index) above the last one emitted
    assign above_prev = !prev_valid_reg || (rdata_reg > prev_val_reg) ||
                        ((rdata_reg == prev_val_reg) && (idx_reg > prev_idx_reg));
    assign below_best = !best_valid_reg || (rdata_reg < best_val_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_re)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            val_reg  <= value;
            nval_reg <= new_value;
        end
        if (cmd.pend_set)
            pend_pos_reg <= idx_pos;
        if (cmd.best_upd && above_prev && below_best)
        begin
            best_val_reg <= rdata_reg;
            best_idx_reg <= idx_reg;
        end
        if (cmd.prev_take)
        begin
            prev_val_reg <= best_val_reg;
            prev_idx_reg <= best_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            k_reg          <= '0;
            match_reg      <= '0;
            pend_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.count_inc)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.count_dec)
                count_reg <= cnt_m1;

            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IDX_W'(1);

            if (cmd.k_clr)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + IDX_W'(1);

            if (cmd.match_clr)
                match_reg <= '0;
            else if (cmd.match_inc)
                match_reg <= match_reg + CNT_W'(1);

            if (cmd.pend_clr)
                pend_valid_reg <= 1'b0;
            else if (cmd.pend_set)
                pend_valid_reg <= 1'b1;

            if (cmd.best_clr)
                best_valid_reg <= 1'b0;
            else if (cmd.best_upd && above_prev && below_best)
                best_valid_reg <= 1'b1;

            if (cmd.prev_clr)
                prev_valid_reg <= 1'b0;
            else if (cmd.prev_take)
                prev_valid_reg <= 1'b1;
        end
    end

    always_comb
    begin
        res_status = ST_OK;
        res_data   = '0;
        res_pos    = '0;
        res_match  = '0;
        res_last   = 1'b1;
        case (cmd.kind)
            RES_FULL:
                res_status = ST_OVERFLOW;
            RES_EMPTY:
                res_status = ST_EMPTY;
            RES_PUSH:
            begin
                res_data = val_reg;
                res_pos  = count_reg;
            end
            RES_POP:
            begin
                res_data = rdata_reg;
                res_pos  = count_reg + CNT_W'(1);
            end
            RES_MATCH:
            begin
                res_data = val_reg;
                res_pos  = pend_pos_reg;
                res_last = cmd.last;
            end
            RES_NOT_FOUND:
                res_status = ST_NOT_FOUND;
            RES_REPLACE:
            begin
                res_status = (match_reg == {CNT_W{1'b0}}) ? ST_NOT_FOUND : ST_OK;
                res_match  = match_reg;
            end
            RES_DISPLAY:
            begin
                res_data = rdata_reg;
                res_pos  = idx_pos;
                res_last = stat.idx_last;
            end
            RES_SORT:
            begin
                res_data = best_val_reg;
                res_last = stat.k_last;
            end
            default:
                res_status = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg    <= res_status;
            data_reg      <= res_data;
            position_reg  <= to_nib(res_pos);
            matches_reg   <= to_nib(res_match);
            count_out_reg <= to_nib(count_reg);
            last_reg      <= res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data        = data_reg;
    assign position    = position_reg;
    assign matches_res = matches_reg;
    assign count       = count_out_reg;
    assign last        = last_reg;

    `BSS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `BSS_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !(out_valid_reg && out_stall))
    `BSS_ASSERT_IMP(a_push_room, clk, rst_n, cmd.mem_we && cmd.wr_top, !stat.count_full)
    `BSS_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.count_dec, !stat.count_zero)
    `BSS_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid_reg)

endmodule

@@ design/bounded_stack_with_search_unit.sv @@
// Top level of the bounded LIFO stack with search, replace, display and sorted readout.
// Depends on bss_pkg, bss_ctrl and bss_datapath.
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_stall   operation, value, new_value
//   out      result     out_valid / out_stall status, data, position, matches_res,
//                                             count, last
//
// One request at a time. Push and pop go through accept, execute and emit.
// Search, replace and display walk the stack through the single read port of the entry
// memory, with a read state and an evaluate state for each entry; search and replace
// close with a final result after the walk. Sorted readout runs a min-selection pass
// over all n entries per result; this scan through the memory port sets its pace.
// Reset clears the entry count and all control state; the entry memory is not swept.
// A stalled output register holds the sequencer wherever the next result is due;
// in_stall is low only while the sequencer is idle.
module bounded_stack_with_search_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic signed [31:0] new_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] data,
    output logic [3:0]         position,
    output logic [3:0]         matches_res,
    output logic [3:0]         count,
    output logic               last
);
    import bss_pkg::*;

    // command and status bundles between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: decode the request, walk the entries, pace the results
    bss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: entry memory, count, scan and sort registers, result register
    bss_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .new_value   (new_value),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .status      (status),
        .data        (data),
        .position    (position),
        .matches_res (matches_res),
        .count       (count),
        .last        (last)
    );

endmodule

@@ verif/tb_bounded_stack_with_search_unit.sv @@
// Self-checking testbench for bounded_stack_with_search_unit: directed and random requests
// with an in-bench stack predictor, checked field by field. Depends on bss_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bounded_stack_with_search_unit;
    import bss_pkg::*;

    localparam int          CLK_PERIOD   = 12;
    localparam int          RANDOM_REQS  = 175;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          HOLD_CYCLES  = 90;
    localparam int          HOLD_AT_REQ  = 45;
    // Codes the block ignores: no result, no state change.
    localparam logic [2:0]  OP_SPARE_A   = 3'd6;
    localparam logic [2:0]  OP_SPARE_B   = 3'd7;
    localparam logic [31:0] MAX_POS      = 32'h7fff_ffff;
    localparam logic [31:0] MIN_NEG      = 32'h8000_0000;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic signed [31:0] new_value;
    } stack_req_t;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [3:0]         position;
        logic [3:0]         matches_res;
        logic [3:0]         count;
        logic               last;
    } stack_result_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [2:0]         operation   = OP_PUSH;
    logic signed [31:0] value       = '0;
    logic signed [31:0] new_value   = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [3:0]         position;
    logic [3:0]         matches_res;
    logic [3:0]         count;
    logic               last;

    // Requests waiting to be offered, and results the predictor says are due.
    stack_req_t         pending_reqs[$];
    stack_result_t      results_due[$];

    // Predictor state: a private copy of the stack.
    logic signed [31:0] model_entries[DEPTH];
    int                 model_depth = 0;

    int reqs_total     = 0;
    int reqs_accepted  = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int overflows_seen = 0;
    int empties_seen   = 0;
    int misses_seen    = 0;
    int cycle_cnt      = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int tx_idle_pct;
    int rx_idle_pct;

    bounded_stack_with_search_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .value       (value),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .data        (data),
        .position    (position),
        .matches_res (matches_res),
        .count       (count),
        .last        (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Idle profile: sender 32% / receiver 74% for the first third of the requests,
    // swapped for the second third, then no idling at all.
    assign tx_idle_pct = (reqs_accepted < reqs_total / 3) ? 32 :
                         (reqs_accepted < 2 * reqs_total / 3) ? 74 : 0;
    assign rx_idle_pct = (reqs_accepted < reqs_total / 3) ? 74 :
                         (reqs_accepted < 2 * reqs_total / 3) ? 32 : 0;

    function automatic void add_req(logic [2:0] op, logic signed [31:0] v,
                                    logic signed [31:0] nv);
        stack_req_t req;
        req.op        = op;
        req.value     = v;
        req.new_value = nv;
        pending_reqs.push_back(req);
        reqs_total++;
    endfunction

    // Mostly a small pool so that searches and replaces hit, plus extremes and noise.
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(6) - 3;
        if (r < 80)
        begin
            case ($urandom_range(3))
                0:       return MAX_POS;
                1:       return MIN_NEG;
                2:       return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic void due_result(logic [1:0] st, logic signed [31:0] d, int pos,
                                       int matched, logic is_last);
        stack_result_t res;
        res.status      = st;
        res.data        = d;
        res.position    = 4'(pos);
        res.matches_res = 4'(matched);
        res.count       = 4'(model_depth);
        res.last        = is_last;
        results_due.push_back(res);
    endfunction

    // Work out the results of one accepted request and advance the stack copy.
    function automatic void predict_stack_op(logic [2:0] op, logic signed [31:0] v,
                                             logic signed [31:0] nv);
        logic signed [31:0] sorted[DEPTH];
        logic signed [31:0] swap;
        int                 hits;
        int                 emitted;

        if (op == OP_SPARE_A || op == OP_SPARE_B)
            return;

        if (op == OP_PUSH)
        begin
            if (model_depth >= DEPTH)
                due_result(ST_OVERFLOW, 0, 0, 0, 1'b1);
            else
            begin
                model_entries[model_depth] = v;
                model_depth++;
                due_result(ST_OK, v, model_depth, 0, 1'b1);
            end
            return;
        end

        // Every other operation on an empty stack reports empty once.
        if (model_depth == 0)
        begin
            due_result(ST_EMPTY, 0, 0, 0, 1'b1);
            return;
        end

        case (op)
            OP_POP:
            begin
                model_depth--;
                due_result(ST_OK, model_entries[model_depth], model_depth + 1, 0, 1'b1);
            end
            OP_SEARCH:
            begin
                hits = 0;
                for (int i = 0; i < model_depth; i++)
                    if (model_entries[i] == v)
                        hits++;
                if (hits == 0)
                    due_result(ST_NOT_FOUND, 0, 0, 0, 1'b1);
                emitted = 0;
                for (int i = 0; i < model_depth; i++)
                    if (model_entries[i] == v)
                    begin
                        emitted++;
                        due_result(ST_OK, v, i + 1, 0, emitted == hits);
                    end
            end
            OP_REPLACE:
            begin
                hits = 0;
                for (int i = 0; i < model_depth; i++)
                    if (model_entries[i] == v)
                    begin
                        model_entries[i] = nv;
                        hits++;
                    end
                due_result((hits != 0) ? ST_OK : ST_NOT_FOUND, 0, 0, hits, 1'b1);
            end
            OP_DISPLAY:
            begin
                for (int i = 0; i < model_depth; i++)
                    due_result(ST_OK, model_entries[i], i + 1, 0, i + 1 == model_depth);
            end
            OP_SORT:
            begin
                // Ascending signed order; the stack itself stays as it is.
                for (int i = 0; i < model_depth; i++)
                    sorted[i] = model_entries[i];
                for (int i = 0; i + 1 < model_depth; i++)
                    for (int j = i + 1; j < model_depth; j++)
                        if (sorted[i] > sorted[j])
                        begin
                            swap      = sorted[i];
                            sorted[i] = sorted[j];
                            sorted[j] = swap;
                        end
                for (int i = 0; i < model_depth; i++)
                    due_result(ST_OK, sorted[i], 0, 0, i + 1 == model_depth);
            end
            default: ;
        endcase
    endfunction

    function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Request driver: offer the next pending request, hold it while stalled,
    // and hand each accepted request to the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        stack_req_t req;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            operation   <= OP_PUSH;
            value       <= '0;
            new_value   <= '0;
            model_depth = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_stack_op(operation, value, new_value);
                reqs_accepted <= reqs_accepted + 1;
            end
            // A stalled request stays on the bus untouched.
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    req = pending_reqs.pop_front();
                    in_valid  <= 1'b1;
                    operation <= req.op;
                    value     <= req.value;
                    new_value <= req.new_value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result stall: random per the idle profile, plus one long hold-off so the
    // output register backs up and the block stalls its request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && reqs_accepted >= HOLD_AT_REQ)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Result monitor: compare every accepted result with the oldest one due.
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            case (status)
                ST_OVERFLOW:  overflows_seen++;
                ST_EMPTY:     empties_seen++;
                ST_NOT_FOUND: misses_seen++;
                default: ;
            endcase
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d data %0h position %0d",
                         $time, status, data, position);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                mismatches += field_differs("status", want.status, status);
                mismatches += field_differs("data", want.data, data);
                mismatches += field_differs("position", want.position, position);
                mismatches += field_differs("matches_res", want.matches_res, matches_res);
                mismatches += field_differs("count", want.count, count);
                mismatches += field_differs("last", want.last, last);
            end
        end
    end

    initial
    begin
        int  r;
        int  counted;
        bit  timed_out;

        // Directed: every operation other than push on an empty stack.
        add_req(OP_POP, 0, 0);
        add_req(OP_SEARCH, 1, 0);
        add_req(OP_REPLACE, 1, 2);
        add_req(OP_DISPLAY, 0, 0);
        add_req(OP_SORT, 0, 0);
        // Fill to the top with extremes and duplicates, then overflow.
        add_req(OP_PUSH, MAX_POS, 0);
        add_req(OP_PUSH, MIN_NEG, 0);
        add_req(OP_PUSH, -1, 0);
        add_req(OP_PUSH, 0, 0);
        add_req(OP_PUSH, 5, 0);
        add_req(OP_PUSH, 5, 0);
        add_req(OP_PUSH, -1, 0);
        add_req(OP_PUSH, 3, 0);
        add_req(OP_PUSH, 9, 0);
        // Several matches, no match, replace with and without hits.
        add_req(OP_SEARCH, 5, 0);
        add_req(OP_SEARCH, 12345, 0);
        add_req(OP_SEARCH, MIN_NEG, 0);
        add_req(OP_REPLACE, 5, -7);
        add_req(OP_REPLACE, 99, MAX_POS);
        add_req(OP_DISPLAY, 0, 0);
        add_req(OP_SORT, 0, 0);
        add_req(OP_POP, 0, 0);
        // Ignored codes must leave no trace.
        add_req(OP_SPARE_A, MAX_POS, MIN_NEG);
        add_req(OP_SPARE_B, -1, -1);
        add_req(OP_POP, 0, 0);

        // Random: push-leaning mix so the stack fills and overflows, with
        // occasional pop bursts that drain it to empty.
        counted = 0;
        while (counted < RANDOM_REQS)
        begin
            r = $urandom_range(99);
            if (r < 38)
                add_req(OP_PUSH, pick_value(), $urandom);
            else if (r < 52)
                add_req(OP_POP, $urandom, $urandom);
            else if (r < 55)
            begin
                repeat (DEPTH + 1)
                    add_req(OP_POP, $urandom, $urandom);
                counted += DEPTH;
            end
            else if (r < 67)
                add_req(OP_SEARCH, pick_value(), $urandom);
            else if (r < 78)
                add_req(OP_REPLACE, pick_value(), pick_value());
            else if (r < 87)
                add_req(OP_DISPLAY, $urandom, $urandom);
            else if (r < 95)
                add_req(OP_SORT, $urandom, $urandom);
            else
            begin
                add_req($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B, $urandom, $urandom);
                continue;
            end
            counted++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go in and every due result to come out.
        while ((reqs_accepted != reqs_total || results_due.size() != 0)
               && cycle_cnt < CYCLE_LIMIT)
            @(negedge clk);
        timed_out = (cycle_cnt >= CYCLE_LIMIT);

        if (timed_out)
        begin
            $display("%0t: timeout with %0d requests left and %0d results due",
                     $time, reqs_total - reqs_accepted, results_due.size());
            $display("Test completed with failures");
        end
        else
        begin
            // Let any stray result show up before closing.
            repeat (DRAIN_CYCLES) @(negedge clk);
            if (results_due.size() != 0)
            begin
                $display("%0t: %0d results never arrived", $time, results_due.size());
                mismatches++;
            end
            $display("Ran %0d requests, checked %0d results with %0d mismatches.",
                     reqs_accepted, results_seen, mismatches);
            $display("Saw %0d overflow, %0d empty and %0d not-found results.",
                     overflows_seen, empties_seen, misses_seen);
            if (mismatches == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule
